[rtl/pdlr_pkg.sv]
// ----------------------------------------------------------------------------
// pdlr_pkg
// Shared constants for the pcm downmix linear resampler.
// ----------------------------------------------------------------------------
package pdlr_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int OUTPUT_RATE_DEF  = 16000;
  localparam int MAX_RESULTS      = 8;

  localparam int RAW_W  = 32;
  localparam int PCM_W  = 16;
  localparam int FMT_W  = 2;
  localparam int CNT_W  = 4;
  localparam int RATE_W = 18;
  localparam int CFG_W  = 18;
  localparam int IDX_W  = 2;

  // quotient bits of the output quantizer
  localparam int QB = 15;

  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_F32 = 2'd3;

  localparam logic [IDX_W-1:0] REG_FORMAT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHANNELS = 2'd1;
  localparam logic [IDX_W-1:0] REG_RATE     = 2'd2;

  localparam logic [PCM_W-1:0] PCM_POS_MAX = 16'h7fff;
  localparam logic [PCM_W-1:0] PCM_NEG_MAX = 16'h8000;

endpackage

[rtl/pdlr_sdiv.sv]
// ----------------------------------------------------------------------------
// pdlr_sdiv
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdlr_sdiv #(
  parameter int NB = 16,
  parameter int VW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NB-1:0] num_i,
  input  logic [VW-1:0] rem_i,
  input  logic [VW-1:0] div_i,
  output logic          done_o,
  output logic [NB-1:0] quo_o,
  output logic [VW-1:0] rem_o
);

  localparam int CW = $clog2(NB + 1);

  logic [VW-1:0] rem_q, rem_d;
  logic [NB-1:0] sh_q, sh_d;
  logic [VW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, sh_q[NB-1]};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
    sh_d  = {sh_q[NB-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      sh_q  <= num_i;
      div_q <= div_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;
  assign rem_o  = rem_q;

endmodule

[rtl/pcm_downmix_linear_resampler_top.sv]
// ----------------------------------------------------------------------------
// pcm_downmix_linear_resampler_top
// Decodes channel samples, averages each frame to mono and resamples it.
// ----------------------------------------------------------------------------
// Input requests carry one raw channel sample on raw_sample_i (in_valid_i /
// in_stall_o). Result requests carry pcm_sample_o and last_of_run_o
// (out_valid_o / out_stall_i); one input gives zero to eight results.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the
// user must write it only while the block is idle, the block itself does not
// enforce this. Every write to a known register restarts the stream.
// Processing, one item at a time:
//   - a sample that does not close a frame is only added to the running sum
//   - passthrough (mono s16 at the output rate) goes straight to the output reg
//   - closing a frame: the serial averaging divider over SW quotient bits
//     (SW = 32 + log2(MAX_CHANNELS)), then per result the serial interpolation
//     multiplier (PW = bits of OUTPUT_RATE, only when resampling), a quantizer
//     setup step and, unless the result saturates, the serial rounding divider
// The output register holds a finished result; the next input is taken while
// it waits. A stalled receiver only holds the block when a new result is
// ready to go. Reset restores format s16, one channel, 16 kHz source rate and
// an empty stream; when resampling, the first mono sample is only stored.
// ----------------------------------------------------------------------------
module pcm_downmix_linear_resampler_top
  import pdlr_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int OUTPUT_RATE  = OUTPUT_RATE_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [RAW_W-1:0]        raw_sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [PCM_W-1:0] pcm_sample_o,
  output logic                    last_of_run_o
);

  localparam int SW   = 32 + $clog2(MAX_CHANNELS);
  localparam int CIW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NVW  = $clog2(MAX_CHANNELS + 1);
  localparam int PW   = $clog2(OUTPUT_RATE + 1);
  localparam int PHW  = $clog2(OUTPUT_RATE + 2 ** RATE_W);
  localparam int AW   = 33 + PW;
  localparam int MCW  = $clog2(PW + 1);
  localparam int MIN_STEP = (OUTPUT_RATE + MAX_RESULTS - 1) / MAX_RESULTS;
  localparam int KW   = $clog2(MAX_RESULTS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MIX  = 6'b000010,
    S_MUL  = 6'b000100,
    S_QNT  = 6'b001000,
    S_QDIV = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [FMT_W-1:0]  fmt_q, fmt_d;
  logic [CNT_W-1:0]  cc_q, cc_d;
  logic [RATE_W-1:0] rate_q, rate_d;

  logic [CIW-1:0]        ch_idx_q, ch_idx_d;
  logic signed [SW-1:0]  mix_q, mix_d;
  logic signed [31:0]    prev_q, prev_d;
  logic signed [31:0]    mono_q, mono_d;
  logic                  primed_q, primed_d;
  logic [PHW-1:0]        phase_q, phase_d;
  logic [KW-1:0]         k_q, k_d;
  logic                  single_q, single_d;
  logic                  sneg_q, sneg_d;

  logic signed [AW-1:0] acc_q, acc_d;
  logic [PW-1:0]        mph_q, mph_d, mrp_q, mrp_d;
  logic [MCW-1:0]       mcnt_q, mcnt_d;

  logic qneg_q, qneg_d, low30_q, low30_d, lrest_q, lrest_d;

  logic [PCM_W-1:0] res_q, res_d;
  logic             rlast_q, rlast_d;
  logic             out_valid_q, out_valid_d;
  logic [PCM_W-1:0] out_pcm_q, out_pcm_d;
  logic             out_last_q, out_last_d;

  // serial dividers
  logic              div1_start, div1_done;
  logic [SW-1:0]     div1_num, div1_quo;
  logic [NVW-1:0]    div1_rem;
  logic              div2_start, div2_done;
  logic [QB-1:0]     div2_num, div2_quo;
  logic [PW-1:0]     div2_remi, div2_rem;

  // datapath helpers
  logic signed [31:0]    dec;
  logic [31:0]           fmag;
  logic [7:0]            fexp;
  logic [23:0]           fman;
  logic signed [SW-1:0]  sum;
  logic [NVW-1:0]        n_eff;
  logic                  pass, acc_in, out_free;
  logic [RATE_W-1:0]     step;
  logic [PHW-1:0]        nph;
  logic [PW-1:0]         den_w;
  logic signed [AW-1:0]  den_s, add_m, add_p;
  logic [AW-1:0]         mag;
  logic [AW+14:0]        aq;
  logic [PW:0]           tq;
  logic                  rnd_up;
  logic [PCM_W-1:0]      qinc;
  logic signed [31:0]    mono_c;

  always_comb begin
    fexp = raw_sample_i[30:23];
    fman = {1'b1, raw_sample_i[22:0]};
    if (fexp >= 8'd119) begin
      fmag = {8'h00, fman} << (fexp - 8'd119);
    end else begin
      fmag = {8'h00, fman} >> (8'd119 - fexp);
    end
    unique case (fmt_q)
      FMT_U8:  dec = {~raw_sample_i[7], raw_sample_i[6:0], 24'h000000};
      FMT_S16: dec = {raw_sample_i[15:0], 16'h0000};
      FMT_S32: dec = raw_sample_i;
      default: begin
        priority if (fexp == 8'hff && raw_sample_i[22:0] != 23'h0) begin
          dec = '0;
        end else if (fexp >= 8'd127) begin
          dec = raw_sample_i[31] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (fexp == 8'h00) begin
          dec = '0;
        end else begin
          dec = raw_sample_i[31] ? -$signed(fmag) : $signed(fmag);
        end
      end
    endcase
  end

  always_comb begin
    if (cc_q == '0) begin
      n_eff = NVW'(1);
    end else if (32'(cc_q) > MAX_CHANNELS) begin
      n_eff = NVW'(MAX_CHANNELS);
    end else begin
      n_eff = NVW'(cc_q);
    end
  end

  assign pass = (fmt_q == FMT_S16) && (cc_q == CNT_W'(1)) &&
                (rate_q == RATE_W'(OUTPUT_RATE));
  assign sum  = mix_q + {{(SW-32){dec[31]}}, dec};
  assign step = (rate_q < RATE_W'(MIN_STEP)) ? RATE_W'(MIN_STEP) : rate_q;
  assign nph  = phase_q + PHW'(step);
  assign in_stall_o = (state_q != S_IDLE);
  assign acc_in     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign den_w  = single_q ? PW'(1) : PW'(OUTPUT_RATE);
  assign den_s  = {2'b00, den_w, 31'h0};
  assign mag    = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
  assign aq     = {mag, 15'h0} - {15'h0, mag};
  assign tq     = {div2_rem, low30_q};
  assign add_m  = mph_q[PW-1] ? {{(AW-32){mono_q[31]}}, mono_q} : '0;
  assign add_p  = mrp_q[PW-1] ? {{(AW-32){prev_q[31]}}, prev_q} : '0;
  assign mono_c = sneg_q ? -$signed(div1_quo[31:0]) : $signed(div1_quo[31:0]);

  always_comb begin
    // round half to even on the serial quotient
    rnd_up = (tq > {1'b0, den_w}) || (tq == {1'b0, den_w} && lrest_q) ||
             (tq == {1'b0, den_w} && !lrest_q && div2_quo[0]);
    qinc = {1'b0, div2_quo} + PCM_W'(rnd_up);
    if (qinc > PCM_POS_MAX) begin
      qinc = PCM_POS_MAX;
    end
  end

  always_comb begin
    state_d     = state_q;
    fmt_d       = fmt_q;
    cc_d        = cc_q;
    rate_d      = rate_q;
    ch_idx_d    = ch_idx_q;
    mix_d       = mix_q;
    prev_d      = prev_q;
    mono_d      = mono_q;
    primed_d    = primed_q;
    phase_d     = phase_q;
    k_d         = k_q;
    single_d    = single_q;
    sneg_d      = sneg_q;
    acc_d       = acc_q;
    mph_d       = mph_q;
    mrp_d       = mrp_q;
    mcnt_d      = mcnt_q;
    qneg_d      = qneg_q;
    low30_d     = low30_q;
    lrest_d     = lrest_q;
    res_d       = res_q;
    rlast_d     = rlast_q;
    out_valid_d = out_valid_q;
    out_pcm_d   = out_pcm_q;
    out_last_d  = out_last_q;
    div1_start  = 1'b0;
    div1_num    = sum[SW-1] ? SW'(-sum) : SW'(sum);
    div2_start  = 1'b0;
    div2_num    = aq[31 +: QB];
    div2_remi   = aq[31 + QB +: PW];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          if (pass) begin
            res_d    = raw_sample_i[PCM_W-1:0];
            rlast_d  = 1'b1;
            single_d = 1'b1;
            state_d  = S_OUT;
          end else if (NVW'(ch_idx_q) + NVW'(1) < n_eff) begin
            ch_idx_d = ch_idx_q + CIW'(1);
            mix_d    = sum;
          end else begin
            ch_idx_d   = '0;
            mix_d      = '0;
            sneg_d     = sum[SW-1];
            div1_start = 1'b1;
            state_d    = S_MIX;
          end
        end
      end
      S_MIX: begin
        if (div1_done) begin
          mono_d = mono_c;
          if (rate_q == RATE_W'(OUTPUT_RATE)) begin
            acc_d    = {{(AW-32){mono_c[31]}}, mono_c};
            single_d = 1'b1;
            state_d  = S_QNT;
          end else if (!primed_q) begin
            prev_d   = mono_c;
            primed_d = 1'b1;
            state_d  = S_IDLE;
          end else if (phase_q >= PHW'(OUTPUT_RATE)) begin
            phase_d = phase_q - PHW'(OUTPUT_RATE);
            prev_d  = mono_c;
            state_d = S_IDLE;
          end else begin
            single_d = 1'b0;
            k_d      = '0;
            acc_d    = '0;
            mph_d    = phase_q[PW-1:0];
            mrp_d    = PW'(OUTPUT_RATE) - phase_q[PW-1:0];
            mcnt_d   = MCW'(PW);
            state_d  = S_MUL;
          end
        end
      end
      S_MUL: begin
        // msb first shift-add of prev*(R-phase) + cur*phase
        acc_d  = (acc_q <<< 1) + add_m + add_p;
        mph_d  = mph_q << 1;
        mrp_d  = mrp_q << 1;
        mcnt_d = mcnt_q - MCW'(1);
        if (mcnt_q == MCW'(1)) begin
          state_d = S_QNT;
        end
      end
      S_QNT: begin
        rlast_d = single_q || (nph >= PHW'(OUTPUT_RATE)) ||
                  (k_q == KW'(MAX_RESULTS - 1));
        if (acc_q <= -den_s) begin
          res_d   = PCM_NEG_MAX;
          state_d = S_OUT;
        end else if (acc_q >= den_s) begin
          res_d   = PCM_POS_MAX;
          state_d = S_OUT;
        end else begin
          qneg_d     = acc_q[AW-1];
          low30_d    = aq[30];
          lrest_d    = aq[29:0] != 30'h0;
          div2_start = 1'b1;
          state_d    = S_QDIV;
        end
      end
      S_QDIV: begin
        if (div2_done) begin
          res_d   = qneg_q ? PCM_W'(-qinc) : qinc;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pcm_d   = res_q;
          out_last_d  = rlast_q;
          if (single_q) begin
            state_d = S_IDLE;
          end else if (nph < PHW'(OUTPUT_RATE) && k_q != KW'(MAX_RESULTS - 1)) begin
            phase_d = nph;
            k_d     = k_q + KW'(1);
            acc_d   = '0;
            mph_d   = nph[PW-1:0];
            mrp_d   = PW'(OUTPUT_RATE) - nph[PW-1:0];
            mcnt_d  = MCW'(PW);
            state_d = S_MUL;
          end else begin
            phase_d = (nph >= PHW'(OUTPUT_RATE)) ? nph - PHW'(OUTPUT_RATE) : nph;
            prev_d  = mono_q;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // a write to a known register restarts the stream
    if (cfg_we_i && (cfg_idx_i == REG_FORMAT || cfg_idx_i == REG_CHANNELS ||
                     cfg_idx_i == REG_RATE)) begin
      unique case (cfg_idx_i)
        REG_FORMAT:   fmt_d  = cfg_wdata_i[FMT_W-1:0];
        REG_CHANNELS: cc_d   = cfg_wdata_i[CNT_W-1:0];
        REG_RATE:     rate_d = cfg_wdata_i[RATE_W-1:0];
        default:      fmt_d  = fmt_q;
      endcase
      ch_idx_d = '0;
      mix_d    = '0;
      prev_d   = '0;
      primed_d = 1'b0;
      phase_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fmt_q       <= FMT_S16;
      cc_q        <= CNT_W'(1);
      rate_q      <= RATE_W'(OUTPUT_RATE_DEF);
      ch_idx_q    <= '0;
      mix_q       <= '0;
      prev_q      <= '0;
      primed_q    <= 1'b0;
      phase_q     <= '0;
      k_q         <= '0;
      single_q    <= 1'b0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fmt_q       <= fmt_d;
      cc_q        <= cc_d;
      rate_q      <= rate_d;
      ch_idx_q    <= ch_idx_d;
      mix_q       <= mix_d;
      prev_q      <= prev_d;
      primed_q    <= primed_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
      single_q    <= single_d;
      mcnt_q      <= mcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mono_q     <= mono_d;
    sneg_q     <= sneg_d;
    acc_q      <= acc_d;
    mph_q      <= mph_d;
    mrp_q      <= mrp_d;
    qneg_q     <= qneg_d;
    low30_q    <= low30_d;
    lrest_q    <= lrest_d;
    res_q      <= res_d;
    rlast_q    <= rlast_d;
    out_pcm_q  <= out_pcm_d;
    out_last_q <= out_last_d;
  end

  pdlr_sdiv #(
    .NB (SW),
    .VW (NVW)
  ) u_avg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div1_start),
    .num_i   (div1_num),
    .rem_i   ('0),
    .div_i   (n_eff),
    .done_o  (div1_done),
    .quo_o   (div1_quo),
    .rem_o   (div1_rem)
  );

  pdlr_sdiv #(
    .NB (QB),
    .VW (PW)
  ) u_qnt_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div2_start),
    .num_i   (div2_num),
    .rem_i   (div2_remi),
    .div_i   (den_w),
    .done_o  (div2_done),
    .quo_o   (div2_quo),
    .rem_o   (div2_rem)
  );

  assign out_valid_o   = out_valid_q;
  assign pcm_sample_o  = $signed(out_pcm_q);
  assign last_of_run_o = out_last_q;

  // averaging remainder is not needed, it only keeps the divider whole
  logic unused_rem;
  assign unused_rem = ^div1_rem;

  a_out_from_fsm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result loaded outside the output step");

  a_mul_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (phase_q < PHW'(OUTPUT_RATE)))
    else $error("interpolation with phase out of range");

  a_avg_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div1_done |-> (state_q == S_MIX))
    else $error("averaging divider finished while not awaited");

  a_qnt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div2_done |-> (state_q == S_QDIV))
    else $error("quantizer divider finished while not awaited");

endmodule

[tb/pcm_downmix_linear_resampler_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_downmix_linear_resampler_top_tb
// Drives channel samples under changing register settings and random
// backpressure, and checks every output sample against a built-in predictor
// of the decode, downmix, interpolation and quantization path.
// ----------------------------------------------------------------------------
module pcm_downmix_linear_resampler_top_tb;
  import pdlr_pkg::*;

  localparam int                 OUT_RATE   = OUTPUT_RATE_DEF;
  localparam int                 MIN_STEP   = (OUT_RATE + 7) / 8;
  localparam logic [IDX_W-1:0]   REG_UNUSED = 2'd3;
  localparam int                 SETTLE     = 400;
  localparam longint             CYCLE_MAX  = 1000000;

  class resample_scoreboard;
    logic [FMT_W-1:0]  fmt;
    logic [CNT_W-1:0]  chans;
    logic [RATE_W-1:0] rate;
    int unsigned       chan_idx;
    longint            mix_acc;
    longint            prev_mono;
    bit                primed;
    int unsigned       phase;
    logic [PCM_W-1:0]  pcm_q[$];
    bit                last_q[$];
    int                errors;

    function new();
      fmt = FMT_S16; chans = CNT_W'(1); rate = RATE_W'(OUT_RATE);
      errors = 0;
      restart();
    endfunction

    function void restart();
      chan_idx = 0; mix_acc = 0; prev_mono = 0; primed = 0; phase = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FORMAT: begin
          fmt = val[FMT_W-1:0]; restart();
        end
        REG_CHANNELS: begin
          chans = val[CNT_W-1:0]; restart();
        end
        REG_RATE: begin
          rate = val[RATE_W-1:0]; restart();
        end
        default: ;
      endcase
    endfunction

    function longint decode_float(logic [31:0] b);
      logic [7:0]  e;
      logic [23:0] m;
      longint      mag;
      e = b[30:23];
      m = {1'b1, b[22:0]};
      if (e == 8'hff && b[22:0] != 0) return 0;
      if (e >= 127) return b[31] ? -64'sd2147483648 : 64'sd2147483647;
      if (e == 0) return 0;
      if (e >= 119) mag = longint'(m) << (e - 119);
      else if (119 - e >= 24) mag = 0;
      else mag = longint'(m >> (119 - e));
      return b[31] ? -mag : mag;
    endfunction

    function longint to_q31(logic [31:0] raw);
      case (fmt)
        FMT_U8:  return (longint'(raw[7:0]) - 128) * 16777216;
        FMT_S16: return longint'($signed(raw[15:0])) * 65536;
        FMT_S32: return longint'($signed(raw));
        default: return decode_float(raw);
      endcase
    endfunction

    function logic [PCM_W-1:0] quantize(longint num, longint den);
      longint unsigned a, q, r;
      bit neg;
      neg = num < 0;
      if (num <= -den) return PCM_NEG_MAX;
      if (num >= den) return PCM_POS_MAX;
      a = neg ? -num : num;
      a = a * 32767;
      q = a / den;
      r = a % den;
      if (2 * r > den || (2 * r == den && q[0])) q++;
      if (q > 32767) q = 32767;
      return neg ? -q[15:0] : q[15:0];
    endfunction

    function void push(logic [PCM_W-1:0] v, bit last);
      pcm_q.push_back(v);
      last_q.push_back(last);
    endfunction

    function void note_request(logic [31:0] raw);
      int unsigned n, step, k;
      longint      mono, num;
      if (fmt == FMT_S16 && chans == 1 && rate == OUT_RATE) begin
        push(raw[15:0], 1);
        return;
      end
      n = chans;
      if (n < 1) n = 1;
      if (n > MAX_CHANNELS_DEF) n = MAX_CHANNELS_DEF;
      mix_acc += to_q31(raw);
      if (chan_idx + 1 < n) begin
        chan_idx++;
        return;
      end
      mono = mix_acc / longint'(n);
      mix_acc = 0;
      chan_idx = 0;
      if (rate == OUT_RATE) begin
        push(quantize(mono, 64'sd2147483648), 1);
        return;
      end
      if (!primed) begin
        prev_mono = mono;
        primed = 1;
        return;
      end
      step = rate < MIN_STEP ? MIN_STEP : rate;
      k = 0;
      while (phase < OUT_RATE && k < MAX_RESULTS) begin
        num = prev_mono * longint'(OUT_RATE - phase) + mono * longint'(phase);
        push(quantize(num, longint'(OUT_RATE) * 64'sd2147483648), 0);
        phase += step;
        k++;
      end
      if (k > 0) last_q[$] = 1;
      if (phase >= OUT_RATE) phase -= OUT_RATE;
      prev_mono = mono;
    endfunction

    function void check_result(logic [PCM_W-1:0] pcm, logic last);
      logic [PCM_W-1:0] ep;
      bit               el;
      if (pcm_q.size() == 0) begin
        $error("unexpected output sample pcm_sample=%0d", $signed(pcm));
        errors++;
        return;
      end
      ep = pcm_q.pop_front();
      el = last_q.pop_front();
      if (pcm !== ep) begin
        $error("pcm_sample expected %0d actual %0d", $signed(ep), $signed(pcm));
        errors++;
      end
      if (last !== el) begin
        $error("last_of_run expected %0d actual %0d", el, last);
        errors++;
      end
    endfunction

    function int pending();
      return pcm_q.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [IDX_W-1:0]        cfg_idx_i = '0;
  logic [CFG_W-1:0]        cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [RAW_W-1:0]        raw_sample_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [PCM_W-1:0] pcm_sample_o;
  logic                    last_of_run_o;

  resample_scoreboard sb = new();
  longint cycles = 0;
  bit     quiet = 0;      // no gaps or stalls while set
  bit     hold_req = 0;   // receiver holds off for a long stretch

  pcm_downmix_linear_resampler_top DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(pcm_sample_o, last_of_run_o);

  function automatic int gap_len();
    if (quiet) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
  endfunction

  // receiver stall pattern
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        hold_req = 0;
        out_stall_i <= 1'b0;
      end else begin
        n = gap_len();
        out_stall_i <= (n != 0);
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_sample(logic [31:0] raw);
    int n;
    n = gap_len();
    if (n != 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(raw);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_mode(int fmt, int ch, int rate);
    write_reg(REG_FORMAT, CFG_W'(fmt));
    write_reg(REG_CHANNELS, CFG_W'(ch));
    write_reg(REG_RATE, CFG_W'(rate));
  endtask

  function automatic logic [31:0] rand_sample(logic [FMT_W-1:0] fmt);
    logic [31:0] v;
    v = $urandom();
    // floats mostly inside (-1, 1) with a wide spread of exponents
    if (fmt == FMT_F32 && $urandom_range(0, 3) != 0) v[30:23] = 8'($urandom_range(100, 127));
    return v;
  endfunction

  initial begin
    logic [31:0] pass_vals[5] = '{32'h0, 32'h7fff, 32'h8000, 32'hffff, 32'hdeadbeef};
    logic [31:0] flt_vals[10] = '{32'h7fc00000, 32'h7f800000, 32'hff800000, 32'h3f800000,
                                  32'hbf800000, 32'h3f000000, 32'h00000001, 32'hbf400000,
                                  32'h33800000, 32'h80000000};
    int rates[8] = '{2000, 1000, 16000, 192000, 44100, 8000, 23999, 262143};
    int fmt, ch, rate, cnt;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // passthrough after reset
    foreach (pass_vals[i]) send_sample(pass_vals[i]);

    set_mode(FMT_U8, 1, 2000);
    send_sample(32'h0); send_sample(32'hff); send_sample(32'h80); send_sample(32'hffffff7f);

    set_mode(FMT_F32, 2, 1000);
    foreach (flt_vals[i]) send_sample(flt_vals[i]);

    set_mode(FMT_S32, 3, 16000);
    send_sample(32'h80000000); send_sample(32'h80000000); send_sample(32'h80000000);
    send_sample(32'h7fffffff); send_sample(32'h7fffffff); send_sample(32'h7fffffff);

    // channel count zero acts as one, above the max acts as the max
    write_reg(REG_CHANNELS, CFG_W'(0));
    send_sample(32'hffffffff); send_sample(32'h00010000);
    write_reg(REG_CHANNELS, CFG_W'(15));
    repeat (8) send_sample(32'h7fffffff);
    write_reg(REG_UNUSED, 18'h3ffff);
    repeat (8) send_sample(32'h40000000);

    // random settings
    for (int ph = 0; ph < 9; ph++) begin
      fmt  = $urandom_range(0, 3);
      ch   = (ph == 0) ? 8 : $urandom_range(0, 15);
      rate = (ph < 8) ? rates[ph] : $urandom_range(2000, 192000);
      if ($urandom_range(0, 1)) set_mode(fmt, ch, rate);
      else begin
        write_reg(REG_RATE, CFG_W'(rate));
        write_reg(REG_CHANNELS, CFG_W'(ch));
        write_reg(REG_FORMAT, CFG_W'(fmt));
      end
      quiet = (ph == 3);
      if (ph == 1) hold_req = 1;
      cnt = 24;
      for (int i = 0; i < cnt; i++) begin
        if (ph == 5 && i == 14) drain();
        send_sample(rand_sample(fmt[FMT_W-1:0]));
      end
    end
    quiet = 0;

    // passthrough again with random data
    set_mode(FMT_S16, 1, 16000);
    repeat (10) send_sample($urandom());

    drain();
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/pdlr_pkg.sv
rtl/pdlr_sdiv.sv
rtl/pcm_downmix_linear_resampler_top.sv
tb/pcm_downmix_linear_resampler_top_tb.sv
